### rtl/ptrd_pkg.sv
package ptrd_pkg;

  localparam int SLOTS     = 4;
  localparam int SLOT_W    = 2;
  localparam int TIME_W    = 32;
  localparam int MISS_W    = 16;
  localparam int QUEUE_W   = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [TIME_W-1:0]  PERIOD_RESET  = 32'd1000;
  localparam logic [TIME_W-1:0]  RELEASE_RESET = 32'd0;
  localparam logic [MISS_W-1:0]  MISS_SAT      = 16'hFFFF;
  localparam logic [QUEUE_W-1:0] QUEUE_SAT     = 8'hFF;

  // register map: periods first, then first release times
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BASE  = 3'd4;

  typedef enum logic {
    OP_TICK     = 1'b0,
    OP_DISPATCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_BLOCKED = 2'd1,
    ST_EXEC    = 2'd2
  } task_state_t;

endpackage

### rtl/periodic_task_release_dispatcher_top.sv
// an accepted item is held in the input register, then its result is strobed on out_valid from the result register
// throughput: one item per cycle, busy is low in every cycle but the first after reset
// all four tasks are compared and priority encoded combinationally between two registers
// reset (rst_n low at a clock edge): tasks blocked, counters zero, periods 1000, releases 0
// results are a one-cycle strobe; the receiver cannot stall and must take every beat
module periodic_task_release_dispatcher_top #(
  parameter int NUM_TASKS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_op,
  input  logic [ptrd_pkg::TIME_W-1:0]      in_now_ms,
  input  logic [ptrd_pkg::SLOT_W-1:0]      in_query_task,
  output logic                             out_valid,
  output logic                             out_dispatched,
  output logic [ptrd_pkg::SLOT_W-1:0]      out_dispatched_task,
  output logic [1:0]                       out_queried_state,
  output logic [ptrd_pkg::MISS_W-1:0]      out_queried_missed,
  output logic [ptrd_pkg::QUEUE_W-1:0]     out_queried_queue,
  output logic [ptrd_pkg::QUEUE_W-1:0]     out_queried_queue_max,
  input  logic                             cfg_we,
  input  logic [ptrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptrd_pkg::TIME_W-1:0]      cfg_wdata
);
  import ptrd_pkg::*;

  // input register
  logic                busy_r;
  logic                in_vld_r;
  op_t                 op_r;
  logic [TIME_W-1:0]   now_r;
  logic [SLOT_W-1:0]   query_r;

  // task state
  logic [TIME_W-1:0]   period_r        [SLOTS];
  logic [TIME_W-1:0]   period_nxt      [SLOTS];
  logic [TIME_W-1:0]   next_release_r  [SLOTS];
  logic [TIME_W-1:0]   next_release_nxt[SLOTS];
  task_state_t         state_r         [SLOTS];
  task_state_t         state_nxt       [SLOTS];
  logic [MISS_W-1:0]   missed_r        [SLOTS];
  logic [MISS_W-1:0]   missed_nxt      [SLOTS];
  logic [QUEUE_W-1:0]  queue_r         [SLOTS];
  logic [QUEUE_W-1:0]  queue_nxt       [SLOTS];
  logic [QUEUE_W-1:0]  queue_max_r     [SLOTS];
  logic [QUEUE_W-1:0]  queue_max_nxt   [SLOTS];

  // result register
  logic                out_valid_r;
  logic                dispatched_r;
  logic                dispatched_nxt;
  logic [SLOT_W-1:0]   dispatched_task_r;
  logic [SLOT_W-1:0]   dispatched_task_nxt;
  task_state_t         q_state_r;
  logic [MISS_W-1:0]   q_missed_r;
  logic [QUEUE_W-1:0]  q_queue_r;
  logic [QUEUE_W-1:0]  q_queue_max_r;

  logic                accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      in_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_op);
      now_r   <= in_now_ms;
      query_r <= in_query_task;
    end
  end

  always_comb begin
    logic found;
    for (int i = 0; i < SLOTS; i++) begin
      period_nxt[i]       = period_r[i];
      next_release_nxt[i] = next_release_r[i];
      state_nxt[i]        = state_r[i];
      missed_nxt[i]       = missed_r[i];
      queue_nxt[i]        = queue_r[i];
      queue_max_nxt[i]    = queue_max_r[i];
    end
    found               = 1'b0;
    dispatched_task_nxt = '0;

    if (in_vld_r) begin
      if (op_r == OP_TICK) begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (now_r >= next_release_r[i]) begin
            next_release_nxt[i] = next_release_r[i] + period_r[i];
            if (state_r[i] == ST_BLOCKED) begin
              state_nxt[i] = ST_READY;
            end else begin
              // still pending from the last release: deadline missed, job queued
              if (missed_r[i] != MISS_SAT) missed_nxt[i] = missed_r[i] + 16'd1;
              if (queue_r[i] != QUEUE_SAT) queue_nxt[i] = queue_r[i] + 8'd1;
              if (queue_nxt[i] > queue_max_r[i]) queue_max_nxt[i] = queue_nxt[i];
            end
          end
        end
      end else begin
        // lowest index wins
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (!found && state_r[i] == ST_READY) begin
            found               = 1'b1;
            dispatched_task_nxt = SLOT_W'(i);
            if (queue_r[i] != '0) queue_nxt[i] = queue_r[i] - 8'd1;
            state_nxt[i] = ST_BLOCKED;
          end
        end
      end
    end

    // the user must write only while idle; the block itself does not enforce it
    if (cfg_we) begin
      if (cfg_index < CFG_FIRST_BASE) begin
        period_nxt[cfg_index[SLOT_W-1:0]] = cfg_wdata;
      end else begin
        next_release_nxt[cfg_index[SLOT_W-1:0]] = cfg_wdata;
      end
    end

    dispatched_nxt = found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        period_r[i]       <= PERIOD_RESET;
        next_release_r[i] <= RELEASE_RESET;
        state_r[i]        <= ST_BLOCKED;
        missed_r[i]       <= '0;
        queue_r[i]        <= '0;
        queue_max_r[i]    <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        period_r[i]       <= period_nxt[i];
        next_release_r[i] <= next_release_nxt[i];
        state_r[i]        <= state_nxt[i];
        missed_r[i]       <= missed_nxt[i];
        queue_r[i]        <= queue_nxt[i];
        queue_max_r[i]    <= queue_max_nxt[i];
      end
      out_valid_r <= in_vld_r;
    end
  end

  // result beat reports the queried task after this item's update
  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      dispatched_r      <= dispatched_nxt;
      dispatched_task_r <= dispatched_task_nxt;
      q_state_r         <= state_nxt[query_r];
      q_missed_r        <= missed_nxt[query_r];
      q_queue_r         <= queue_nxt[query_r];
      q_queue_max_r     <= queue_max_nxt[query_r];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_dispatched        = dispatched_r;
  assign out_dispatched_task   = dispatched_task_r;
  assign out_queried_state     = q_state_r;
  assign out_queried_missed    = q_missed_r;
  assign out_queried_queue     = q_queue_r;
  assign out_queried_queue_max = q_queue_max_r;

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid)
    else $error("result beat missing after accepted item");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result beat without an accepted item");

  a_dispatched_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && dispatched_r) |-> state_r[dispatched_task_r] == ST_BLOCKED)
    else $error("dispatched task not left blocked");

  a_queue_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> q_queue_r <= q_queue_max_r)
    else $error("queue count above its high-water mark");

endmodule
